// ===== sv/lumh_pkg.sv =====
// Shared types and constants for the luminance histogram.
// Used by every module of the block except lumh_ram; depends on nothing.
package lumh_pkg;

	localparam int NUM_BINS    = 256;
	localparam int BIN_BITS    = 8;
	localparam int COUNT_BITS  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COMP_BITS   = FRAC_BITS + 1;
	localparam int W_SHIFT     = 16;
	localparam int PROD_BITS   = COMP_BITS + W_SHIFT;
	localparam int LUM_BITS    = PROD_BITS + 1;
	localparam int SCALED_BITS = LUM_BITS + BIN_BITS;
	localparam int BIN_SHIFT   = FRAC_BITS + W_SHIFT;

	// Rec. 709 weights in Q0.16, summing to exactly 1.0
	localparam logic [W_SHIFT-1:0] W_RED   = 16'd13933;
	localparam logic [W_SHIFT-1:0] W_GREEN = 16'd46871;
	localparam logic [W_SHIFT-1:0] W_BLUE  = 16'd4732;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_PIXEL = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_BITS   = 3;
	localparam int QCNT_BITS   = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_PIXEL,
		OP_READ
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_DATA
	} back_state_t;

	typedef struct packed {
		logic [1:0]           func;
		logic [COMP_BITS-1:0] red;
		logic [COMP_BITS-1:0] green;
		logic [COMP_BITS-1:0] blue;
		logic [BIN_BITS-1:0]  read_bin;
	} cmd_t;

	typedef struct packed {
		logic [BIN_BITS-1:0]   bin_number;
		logic [COUNT_BITS-1:0] bin_count;
	} result_t;

	// one classified operation between front and back
	typedef struct packed {
		op_t                 op;
		logic [BIN_BITS-1:0] bin;
	} job_t;

endpackage

// ===== sv/lumh_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module lumh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lumh_front.sv =====
// Front end: accepts commands, classifies them and computes the bin of a pixel
// in a three-stage pipeline. Depends on lumh_pkg.
module lumh_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  lumh_pkg::cmd_t                 cmd,
	input  logic [lumh_pkg::QCNT_BITS-1:0] queue_count,
	output logic                           busy,
	output logic                           push,
	output lumh_pkg::job_t                 job
);

	logic                              take;
	logic [lumh_pkg::QCNT_BITS-1:0]    occupancy;
	logic                              v_s1, v_s2, v_s3;
	lumh_pkg::op_t                     op_s1, op_s2;
	logic [lumh_pkg::BIN_BITS-1:0]     bin_s1, bin_s2;
	logic [lumh_pkg::PROD_BITS-1:0]    prod_r_s1, prod_g_s1, prod_b_s1;
	logic [lumh_pkg::LUM_BITS-1:0]     lum_s2;
	logic [lumh_pkg::SCALED_BITS-1:0]  scaled;
	logic [lumh_pkg::SCALED_BITS-lumh_pkg::BIN_SHIFT-1:0] bin_wide;
	logic [lumh_pkg::BIN_BITS-1:0]     pix_bin;
	lumh_pkg::job_t                    job_s3;
	lumh_pkg::op_t                     op_dec;

	// room is reserved in the queue for every item still in the pipeline
	assign occupancy = queue_count + lumh_pkg::QCNT_BITS'(v_s1)
		+ lumh_pkg::QCNT_BITS'(v_s2) + lumh_pkg::QCNT_BITS'(v_s3);
	assign busy = occupancy >= lumh_pkg::QCNT_BITS'(lumh_pkg::QUEUE_DEPTH);
	assign take = start && !busy && (cmd.func != lumh_pkg::FUNC_NONE);

	always_comb begin
		unique case (cmd.func)
			lumh_pkg::FUNC_CLEAR: op_dec = lumh_pkg::OP_CLEAR;
			lumh_pkg::FUNC_PIXEL: op_dec = lumh_pkg::OP_PIXEL;
			default:              op_dec = lumh_pkg::OP_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op_dec;
		bin_s1    <= cmd.read_bin;
		prod_r_s1 <= lumh_pkg::PROD_BITS'(cmd.red * lumh_pkg::W_RED);
		prod_g_s1 <= lumh_pkg::PROD_BITS'(cmd.green * lumh_pkg::W_GREEN);
		prod_b_s1 <= lumh_pkg::PROD_BITS'(cmd.blue * lumh_pkg::W_BLUE);
		op_s2     <= op_s1;
		bin_s2    <= bin_s1;
		lum_s2    <= lumh_pkg::LUM_BITS'(prod_r_s1) + lumh_pkg::LUM_BITS'(prod_g_s1)
			+ lumh_pkg::LUM_BITS'(prod_b_s1);
		job_s3.op <= op_s2;
		job_s3.bin <= (op_s2 == lumh_pkg::OP_PIXEL) ? pix_bin : bin_s2;
	end

	// bin = floor(L * 255 / 2^32), L*255 as (L << 8) - L, clamped to the top bin
	always_comb begin
		scaled   = {lum_s2, {lumh_pkg::BIN_BITS{1'b0}}}
			- lumh_pkg::SCALED_BITS'(lum_s2);
		bin_wide = scaled[lumh_pkg::SCALED_BITS-1:lumh_pkg::BIN_SHIFT];
		if (bin_wide > ($bits(bin_wide))'(lumh_pkg::NUM_BINS - 1)) begin
			pix_bin = lumh_pkg::BIN_BITS'(lumh_pkg::NUM_BINS - 1);
		end else begin
			pix_bin = bin_wide[lumh_pkg::BIN_BITS-1:0];
		end
	end

	assign push = v_s3;
	assign job  = job_s3;

endmodule

// ===== sv/lumh_queue.sv =====
// Short FIFO of classified operations between front and back end.
// Depends on lumh_pkg.
module lumh_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  lumh_pkg::job_t                 job_in,
	input  logic                           pop,
	output lumh_pkg::job_t                 job_out,
	output logic                           not_empty,
	output logic [lumh_pkg::QCNT_BITS-1:0] count
);

	lumh_pkg::job_t                 slot_q [lumh_pkg::QUEUE_DEPTH];
	logic [lumh_pkg::QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [lumh_pkg::QCNT_BITS-1:0] count_q;
	logic                           do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + lumh_pkg::QCNT_BITS'(push)
				- lumh_pkg::QCNT_BITS'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= job_in;
		end
	end

	assign job_out   = slot_q[rptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

// ===== sv/lumh_back.sv =====
// Back end: carries out clear, bin increment and bin read on the count RAM.
// Depends on lumh_pkg and lumh_ram.
module lumh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  lumh_pkg::job_t    job,
	output logic              pop,
	output logic              done,
	output lumh_pkg::result_t result
);

	lumh_pkg::back_state_t              state_q, state_d;
	lumh_pkg::op_t                      op_q;
	logic [lumh_pkg::BIN_BITS-1:0]      bin_q;
	logic [lumh_pkg::NUM_BINS-1:0]      valid_q;
	logic                               done_q;
	lumh_pkg::result_t                  result_q;
	logic [lumh_pkg::COUNT_BITS-1:0]    rdata, cur_count, wdata;
	logic                               we, clr_all, load, emit;

	lumh_ram #(
		.WIDTH(lumh_pkg::COUNT_BITS),
		.DEPTH(lumh_pkg::NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(bin_q),
		.wdata(wdata),
		.raddr(job.bin),
		.rdata(rdata)
	);

	// a bin never written since the last clear reads as zero
	assign cur_count = valid_q[bin_q] ? rdata : '0;
	assign wdata = (cur_count == lumh_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lumh_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		clr_all = 1'b0;
		load    = 1'b0;
		we      = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			lumh_pkg::BK_IDLE: begin
				if (job_valid) begin
					pop = 1'b1;
					if (job.op == lumh_pkg::OP_CLEAR) begin
						clr_all = 1'b1;
					end else begin
						load    = 1'b1;
						state_d = lumh_pkg::BK_DATA;
					end
				end
			end
			lumh_pkg::BK_DATA: begin
				we      = (op_q == lumh_pkg::OP_PIXEL);
				emit    = (op_q == lumh_pkg::OP_READ);
				state_d = lumh_pkg::BK_IDLE;
			end
			default: state_d = lumh_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= emit;
			if (clr_all) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[bin_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= job.op;
			bin_q <= job.bin;
		end
		if (emit) begin
			result_q.bin_number <= bin_q;
			result_q.bin_count  <= cur_count;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/luminance_histogram_top.sv =====
// Luminance histogram, 256 saturating bins: clear, accumulate pixel, read bin.
// A read passes the front pipeline, the queue, and the back end's idle and data states.
// A clear needs only the idle state; a pixel or read also needs the data state for the
// read-modify-write on the count RAM; busy rises while 8 items are queued or in flight.
// Reset: asynchronous, all bins read zero at once through per-bin valid flags.
// Depends on lumh_pkg, lumh_front, lumh_queue, lumh_back, lumh_ram.
module luminance_histogram_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lumh_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done,
	output lumh_pkg::result_t result
);

	logic                           push, pop, job_valid;
	lumh_pkg::job_t                 front_job, back_job;
	logic [lumh_pkg::QCNT_BITS-1:0] queue_count;

	lumh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.queue_count(queue_count),
		.busy       (busy),
		.push       (push),
		.job        (front_job)
	);

	lumh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.job_in   (front_job),
		.pop      (pop),
		.job_out  (back_job),
		.not_empty(job_valid),
		.count    (queue_count)
	);

	lumh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (back_job),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule
